>>> rtl/svg_pkg.sv
// Shared constants, types and helpers of the star polygon vertex generator.
package svg_pkg;

	localparam int MAX_POINTS    = 31;
	localparam int CORDIC_STAGES = 24;
	localparam int XW            = 34;   // CORDIC x/y datapath width
	localparam int ZW            = 34;   // CORDIC residual angle width
	localparam int SW            = 36;   // translate/saturate width

	localparam logic [30:0] GAIN_Q31 = 31'd1304065748;
	localparam logic [63:0] TWO32    = 64'h1_0000_0000;
	localparam logic [31:0] QUARTER  = 32'h4000_0000;
	localparam logic [61:0] HALF_LSB = 62'h4000_0000;

	// arctangent of 2^-i in binary-angle units (full turn = 2^32)
	localparam logic [31:0] ATAN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81,
		32'd41, 32'd20, 32'd10, 32'd5,
		32'd3, 32'd1, 32'd1, 32'd0
	};

	// 2^32 = STEP_Q[p] * 2p + STEP_R[p]; angle step between vertices
	localparam logic [31:0] STEP_Q [32] = '{
		32'd0, 32'd0, 32'd0,
		32'(TWO32 / 64'd6),  32'(TWO32 / 64'd8),  32'(TWO32 / 64'd10),
		32'(TWO32 / 64'd12), 32'(TWO32 / 64'd14), 32'(TWO32 / 64'd16),
		32'(TWO32 / 64'd18), 32'(TWO32 / 64'd20), 32'(TWO32 / 64'd22),
		32'(TWO32 / 64'd24), 32'(TWO32 / 64'd26), 32'(TWO32 / 64'd28),
		32'(TWO32 / 64'd30), 32'(TWO32 / 64'd32), 32'(TWO32 / 64'd34),
		32'(TWO32 / 64'd36), 32'(TWO32 / 64'd38), 32'(TWO32 / 64'd40),
		32'(TWO32 / 64'd42), 32'(TWO32 / 64'd44), 32'(TWO32 / 64'd46),
		32'(TWO32 / 64'd48), 32'(TWO32 / 64'd50), 32'(TWO32 / 64'd52),
		32'(TWO32 / 64'd54), 32'(TWO32 / 64'd56), 32'(TWO32 / 64'd58),
		32'(TWO32 / 64'd60), 32'(TWO32 / 64'd62)
	};

	localparam logic [5:0] STEP_R [32] = '{
		6'd0, 6'd0, 6'd0,
		6'(TWO32 % 64'd6),  6'(TWO32 % 64'd8),  6'(TWO32 % 64'd10),
		6'(TWO32 % 64'd12), 6'(TWO32 % 64'd14), 6'(TWO32 % 64'd16),
		6'(TWO32 % 64'd18), 6'(TWO32 % 64'd20), 6'(TWO32 % 64'd22),
		6'(TWO32 % 64'd24), 6'(TWO32 % 64'd26), 6'(TWO32 % 64'd28),
		6'(TWO32 % 64'd30), 6'(TWO32 % 64'd32), 6'(TWO32 % 64'd34),
		6'(TWO32 % 64'd36), 6'(TWO32 % 64'd38), 6'(TWO32 % 64'd40),
		6'(TWO32 % 64'd42), 6'(TWO32 % 64'd44), 6'(TWO32 % 64'd46),
		6'(TWO32 % 64'd48), 6'(TWO32 % 64'd50), 6'(TWO32 % 64'd52),
		6'(TWO32 % 64'd54), 6'(TWO32 % 64'd56), 6'(TWO32 % 64'd58),
		6'(TWO32 % 64'd60), 6'(TWO32 % 64'd62)
	};

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] outer_radius;
		logic signed [31:0] inner_radius;
		logic [7:0]         point_count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic               starts_path;
		logic               last;
	} vtx_t;

	// one vertex as issued by the sequencer
	typedef struct packed {
		logic [31:0]        phase;
		logic [30:0]        radius;
		logic               starts;
		logic               last;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} issue_t;

	// one vertex inside the CORDIC pipe
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
		logic                 starts;
		logic                 last;
		logic signed [31:0]   cx;
		logic signed [31:0]   cy;
	} rot_t;

	// magnitude of a signed word, most negative value saturates
	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		logic [31:0] a;
		a = v[31] ? 32'(-v) : 32'(v);
		return a[31] ? 31'h7FFF_FFFF : a[30:0];
	endfunction

endpackage

>>> rtl/svg_req_if.sv
// Request channel: one star description per transfer.
interface svg_req_if import svg_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/svg_vtx_if.sv
// Vertex channel: one outline vertex per transfer.
interface svg_vtx_if import svg_pkg::*; ();
	logic valid;
	logic ready;
	vtx_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/svg_seq.sv
// Request capture and per-vertex angle/radius sequencer.
module svg_seq import svg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	svg_req_if.sink    req,
	input  logic       adv,
	output logic       iss_valid,
	output issue_t     iss
);

	logic               busy_q;
	logic [5:0]         k_q;
	logic [31:0]        q_q;
	logic [5:0]         rem_q;
	logic [4:0]         p_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic [30:0]        outer_q;
	logic [30:0]        inner_q;

	logic [4:0] pc;
	logic [6:0] rsum;
	logic       carry;
	logic [5:0] two_p;
	logic       at_end;

	// clamp requested point count
	always_comb begin
		if (req.data.point_count < 8'd3) begin
			pc = 5'd3;
		end else if (req.data.point_count > 8'(MAX_POINTS)) begin
			pc = 5'(MAX_POINTS);
		end else begin
			pc = req.data.point_count[4:0];
		end
	end

	// running quotient/remainder of (k*2^32 + P) / 2P
	assign two_p  = {p_q, 1'b0};
	assign rsum   = {1'b0, rem_q} + {1'b0, STEP_R[p_q]};
	assign carry  = rsum >= {1'b0, two_p};
	assign at_end = k_q == two_p;

	assign req.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= '0;
			q_q     <= '0;
			rem_q   <= '0;
			p_q     <= 5'd3;
			cx_q    <= '0;
			cy_q    <= '0;
			outer_q <= '0;
			inner_q <= '0;
		end else if (req.valid && req.ready) begin
			busy_q  <= 1'b1;
			k_q     <= '0;
			q_q     <= '0;
			rem_q   <= {1'b0, pc};
			p_q     <= pc;
			cx_q    <= req.data.center_x;
			cy_q    <= req.data.center_y;
			outer_q <= mag31(req.data.outer_radius);
			inner_q <= mag31(req.data.inner_radius);
		end else if (busy_q && adv) begin
			if (at_end) begin
				busy_q <= 1'b0;
				k_q    <= '0;
			end else begin
				k_q   <= k_q + 6'd1;
				q_q   <= q_q + STEP_Q[p_q] + {31'd0, carry};
				rem_q <= carry ? 6'(rsum - {1'b0, two_p}) : rsum[5:0];
			end
		end
	end

	// vertex issued into the pipe
	assign iss_valid  = busy_q;
	assign iss.phase  = QUARTER + q_q;
	assign iss.radius = k_q[0] ? inner_q : outer_q;
	assign iss.starts = k_q == 6'd0;
	assign iss.last   = at_end;
	assign iss.cx     = cx_q;
	assign iss.cy     = cy_q;

endmodule

>>> rtl/svg_cordic.sv
// Quadrant fold, gain-scaled start value and pipelined rotation CORDIC.
module svg_cordic import svg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   in_valid,
	input  issue_t in_data,
	output logic   out_valid,
	output rot_t   out_data
);

	rot_t st_s [CORDIC_STAGES+1];
	logic v_s  [CORDIC_STAGES+1];

	logic        flip;
	logic [31:0] folded;
	logic [61:0] prod;
	rot_t        prep;

	// fold angle into [-pi/2, pi/2), scale radius by 1/gain
	always_comb begin
		flip        = in_data.phase[31] ^ in_data.phase[30];
		folded      = flip ? {~in_data.phase[31], in_data.phase[30:0]} : in_data.phase;
		prod        = 62'(in_data.radius) * 62'(GAIN_Q31) + HALF_LSB;
		prep.x      = XW'(prod[61:31]);
		prep.y      = '0;
		prep.z      = ZW'($signed(folded));
		prep.flip   = flip;
		prep.starts = in_data.starts;
		prep.last   = in_data.last;
		prep.cx     = in_data.cx;
		prep.cy     = in_data.cy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= prep;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		rot_t nxt;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [ZW-1:0] da;

		always_comb begin
			nxt = st_s[i];
			dx  = st_s[i].y >>> i;
			dy  = st_s[i].x >>> i;
			da  = ZW'(ATAN[i]);
			if (!st_s[i].z[ZW-1]) begin
				nxt.x = st_s[i].x - dx;
				nxt.y = st_s[i].y + dy;
				nxt.z = st_s[i].z - da;
			end else begin
				nxt.x = st_s[i].x + dx;
				nxt.y = st_s[i].y - dy;
				nxt.z = st_s[i].z + da;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[i+1] <= nxt;
			end
		end
	end

	assign out_valid = v_s[CORDIC_STAGES];
	assign out_data  = st_s[CORDIC_STAGES];

endmodule

>>> rtl/svg_post.sv
// Unfold, translate by center, saturate and hold the output vertex.
module svg_post import svg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  rot_t     in_data,
	output logic     adv,
	svg_vtx_if.source vtx
);

	logic                 vld_q;
	vtx_t                 dat_q;
	logic signed [XW-1:0] ux;
	logic signed [XW-1:0] uy;
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sy;
	logic signed [31:0]   satx;
	logic signed [31:0]   saty;

	localparam logic signed [SW-1:0] SMAX = SW'(64'sh7FFF_FFFF);
	localparam logic signed [SW-1:0] SMIN = -SW'(64'sh8000_0000);

	// undo quadrant fold, add center, clamp to 32 bits
	always_comb begin
		ux = in_data.flip ? -in_data.x : in_data.x;
		uy = in_data.flip ? -in_data.y : in_data.y;
		sx = SW'(in_data.cx) + SW'(ux);
		sy = SW'(in_data.cy) + SW'(uy);
		if (sx > SMAX) begin
			satx = 32'sh7FFF_FFFF;
		end else if (sx < SMIN) begin
			satx = 32'sh8000_0000;
		end else begin
			satx = sx[31:0];
		end
		if (sy > SMAX) begin
			saty = 32'sh7FFF_FFFF;
		end else if (sy < SMIN) begin
			saty = 32'sh8000_0000;
		end else begin
			saty = sy[31:0];
		end
	end

	// whole pipe moves when the output slot is free or being taken
	assign adv = !vld_q || vtx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dat_q.vertex_x    <= satx;
			dat_q.vertex_y    <= saty;
			dat_q.starts_path <= in_data.starts;
			dat_q.last        <= in_data.last;
		end
	end

	assign vtx.valid = vld_q;
	assign vtx.data  = dat_q;

endmodule

>>> rtl/star_polygon_vertex_generator.sv
// Top level of the star polygon vertex generator.
//
// Channels: req takes one star (center, outer and inner radius, point
// count); vtx returns 2*P+1 outline vertices in Q16.16, P being the count
// clamped to 3..31. The first vertex has starts_path set, the final one
// (back on the starting angle) has last set; the path closes after it.
// Radii use their magnitude; coordinates saturate to 32 bits.
// Pipeline: a vertex passes one issue stage, one prep stage, 24 CORDIC
// stages and the output register.
// Throughput: one vertex per cycle while vtx is taken; a request keeps
// the sequencer busy until its last vertex is issued, and the next
// request is taken only once it is idle. Requests of one star overlap
// in the pipe with the tail of the previous one.
// Reset: all valid bits clear, sequencer idle, ready high.
// Stall: when vtx is not taken the whole pipe and sequencer hold; nothing
// is dropped or repeated.
module star_polygon_vertex_generator import svg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	svg_req_if.sink  req,
	svg_vtx_if.source vtx
);

	logic   adv;
	logic   iss_valid;
	issue_t iss;
	logic   rot_valid;
	rot_t   rot;

	svg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.adv       (adv),
		.iss_valid (iss_valid),
		.iss       (iss)
	);

	svg_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (iss_valid),
		.in_data   (iss),
		.out_valid (rot_valid),
		.out_data  (rot)
	);

	svg_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rot_valid),
		.in_data  (rot),
		.adv      (adv),
		.vtx      (vtx)
	);

endmodule
